// ===== rtl/work_stealing_multi_queue_defines.svh =====
// ----------------------------------------------------------------------------
// Work stealing multi queue: assertion macros
// Shared concurrent check shorthands, sampled on clk, off during rst.
// ----------------------------------------------------------------------------
`ifndef WORK_STEALING_MULTI_QUEUE_DEFINES_SVH
`define WORK_STEALING_MULTI_QUEUE_DEFINES_SVH

// same-cycle implication
`define WSMQ_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wsmq: same-cycle check failed");

// next-cycle implication
`define WSMQ_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wsmq: next-cycle check failed");

`endif

// ===== rtl/wsmq_pkg.sv =====
// ----------------------------------------------------------------------------
// wsmq_pkg
// Sizes, codes and shared types of the work stealing multi queue.
// ----------------------------------------------------------------------------
package wsmq_pkg;

  localparam int NUM_QUEUES  = 8;
  localparam int QUEUE_DEPTH = 16;
  localparam int ITEM_WIDTH  = 32;

  localparam int QW    = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int NCW   = $clog2(NUM_QUEUES + 1);
  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int FW    = $clog2(QUEUE_DEPTH + 1);
  localparam int AW    = $clog2(NUM_QUEUES * QUEUE_DEPTH);
  localparam int MEM_DEPTH = NUM_QUEUES * QUEUE_DEPTH;

  localparam int REQ_W    = 2;
  localparam int IDX_W    = 3;
  localparam int HANDLE_W = 32;
  localparam int STAT_W   = 2;
  localparam int CFG_W    = 4;
  localparam int CW       = (NCW > IDX_W) ? NCW : IDX_W;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH_RR    = 2'd0,
    REQ_PUSH_NAMED = 2'd1,
    REQ_POP        = 2'd2,
    REQ_IGNORE     = 2'd3
  } req_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_PUSHED   = 2'd0,
    STAT_REJECTED = 2'd1,
    STAT_POPPED   = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_RESP = 1'b1
  } state_t;

  typedef struct packed {
    logic             valid;
    status_t          status;
    logic [IDX_W-1:0] src;
    logic             stolen;
  } decision_t;

endpackage

// ===== rtl/wsmq_task_ram.sv =====
// ----------------------------------------------------------------------------
// wsmq_task_ram
// Task item store, one write and/or one registered read per cycle at a shared address.
// ----------------------------------------------------------------------------
module wsmq_task_ram (
  input  logic                            clk,
  input  logic                            we,
  input  logic                            re,
  input  logic [wsmq_pkg::AW-1:0]         addr,
  input  logic [wsmq_pkg::ITEM_WIDTH-1:0] wdata,
  output logic [wsmq_pkg::ITEM_WIDTH-1:0] rdata
);

  logic [wsmq_pkg::ITEM_WIDTH-1:0] mem [wsmq_pkg::MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/wsmq_sched.sv =====
// ----------------------------------------------------------------------------
// wsmq_sched
// Queue pointers, fill counts, push pointer and the steal search.
// ----------------------------------------------------------------------------
`include "work_stealing_multi_queue_defines.svh"

module wsmq_sched (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              fire,
  input  wsmq_pkg::req_t                    req,
  input  logic [wsmq_pkg::IDX_W-1:0]        queue_index,
  input  logic                              cfg_wr_en,
  input  logic [wsmq_pkg::CFG_W-1:0]        cfg_wr_data,
  output wsmq_pkg::decision_t               dec,
  output logic                              mem_we,
  output logic                              mem_re,
  output logic [wsmq_pkg::AW-1:0]           mem_addr
);

  localparam int QW  = wsmq_pkg::QW;
  localparam int NCW = wsmq_pkg::NCW;
  localparam int CW  = wsmq_pkg::CW;
  localparam int PW  = wsmq_pkg::PW;
  localparam int FW  = wsmq_pkg::FW;
  localparam int AW  = wsmq_pkg::AW;
  localparam int NQ  = wsmq_pkg::NUM_QUEUES;
  localparam int QD  = wsmq_pkg::QUEUE_DEPTH;

  logic [PW-1:0]  head [NQ];
  logic [PW-1:0]  tail [NQ];
  logic [FW-1:0]  fill [NQ];
  logic [QW-1:0]  pp;
  logic [QW-1:0]  pp_next;
  logic [NCW-1:0] nq;
  logic [NCW-1:0] nq_new;

  logic [CW-1:0]  idx_c;
  logic [CW-1:0]  nq_c;
  logic           idx_act;
  logic [QW-1:0]  idx_q;
  logic           is_push;
  logic           is_pop;
  logic [QW-1:0]  push_q;
  logic           push_act;
  logic           push_ok;
  logic           own_hit;
  logic           steal_hit;
  logic [QW-1:0]  steal_q;
  logic           pop_hit;
  logic [QW-1:0]  pop_q;

  assign idx_c   = CW'(queue_index);
  assign nq_c    = CW'(nq);
  assign idx_act = idx_c < nq_c;
  assign idx_q   = QW'(queue_index);
  assign is_push = (req == wsmq_pkg::REQ_PUSH_RR) || (req == wsmq_pkg::REQ_PUSH_NAMED);
  assign is_pop  = (req == wsmq_pkg::REQ_POP);
  assign push_q   = (req == wsmq_pkg::REQ_PUSH_RR) ? pp : idx_q;
  assign push_act = (req == wsmq_pkg::REQ_PUSH_RR) ? 1'b1 : idx_act;
  assign push_ok  = is_push && push_act && (fill[push_q] != FW'(QD));
  assign own_hit  = idx_act && (fill[idx_q] != '0);

  // circular scan downward from pp - 1, requester skipped
  always_comb begin
    logic [NCW:0] q;
    steal_hit = 1'b0;
    steal_q   = '0;
    for (int k = 1; k <= NQ; k++) begin
      q = (NCW+1)'(pp) + (NCW+1)'(nq) - (NCW+1)'(k);
      if (q >= (NCW+1)'(nq)) begin
        q = q - (NCW+1)'(nq);
      end
      if (!steal_hit && ((NCW+1)'(k) <= (NCW+1)'(nq)) &&
          (CW'(q) != idx_c) && (fill[QW'(q)] != '0)) begin
        steal_hit = 1'b1;
        steal_q   = QW'(q);
      end
    end
  end

  assign pop_hit = own_hit || steal_hit;
  assign pop_q   = own_hit ? idx_q : steal_q;

  always_comb begin
    dec.valid  = (req != wsmq_pkg::REQ_IGNORE);
    dec.stolen = 1'b0;
    dec.src    = '0;
    dec.status = wsmq_pkg::STAT_EMPTY;
    if (is_push) begin
      dec.status = push_ok ? wsmq_pkg::STAT_PUSHED : wsmq_pkg::STAT_REJECTED;
      dec.src    = (req == wsmq_pkg::REQ_PUSH_RR) ? wsmq_pkg::IDX_W'(pp) : queue_index;
    end else if (is_pop && pop_hit) begin
      dec.status = wsmq_pkg::STAT_POPPED;
      dec.src    = wsmq_pkg::IDX_W'(pop_q);
      dec.stolen = !own_hit;
    end
  end

  assign mem_we   = fire && push_ok;
  assign mem_re   = fire && is_pop && pop_hit;
  assign mem_addr = is_push ? (AW'(push_q) * AW'(QD) + AW'(tail[push_q]))
                            : (AW'(pop_q) * AW'(QD) + AW'(head[pop_q]));

  always_comb begin
    pp_next = pp;
    if ((NCW+1)'(pp) + 1'b1 >= (NCW+1)'(nq)) begin
      pp_next = '0;
    end else begin
      pp_next = pp + 1'b1;
    end
  end

  always_comb begin
    if (cfg_wr_data == '0) begin
      nq_new = NCW'(1);
    end else if (int'(cfg_wr_data) > NQ) begin
      nq_new = NCW'(NQ);
    end else begin
      nq_new = NCW'(cfg_wr_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pp <= '0;
      nq <= NCW'(NQ);
      for (int i = 0; i < NQ; i++) begin
        head[i] <= '0;
        tail[i] <= '0;
        fill[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        nq <= nq_new;
        if (NCW'(pp) >= nq_new) begin
          pp <= '0;
        end
      end
      if (fire && (req == wsmq_pkg::REQ_PUSH_RR)) begin
        pp <= pp_next;
      end
      if (fire && push_ok) begin
        tail[push_q] <= (tail[push_q] == PW'(QD - 1)) ? '0 : tail[push_q] + 1'b1;
        fill[push_q] <= fill[push_q] + 1'b1;
      end
      if (fire && is_pop && pop_hit) begin
        head[pop_q] <= (head[pop_q] == PW'(QD - 1)) ? '0 : head[pop_q] + 1'b1;
        fill[pop_q] <= fill[pop_q] - 1'b1;
      end
    end
  end

  `WSMQ_ASSERT_IMPL(a_pp_active, 1'b1, NCW'(pp) < nq)
  `WSMQ_ASSERT_IMPL(a_nq_range, 1'b1, (nq != '0) && (int'(nq) <= NQ))
  `WSMQ_ASSERT_IMPL(a_one_mem_op, fire, !(mem_we && mem_re))
  `WSMQ_ASSERT_NEXT(a_rr_moves, fire && (req == wsmq_pkg::REQ_PUSH_RR) && (nq != NCW'(1)), pp != $past(pp))

endmodule

// ===== rtl/work_stealing_multi_queue.sv =====
// Path: an accepted beat is registered as its decision and memory read (dec_q and the
//   RAM read data), which are then loaded into the output register for the master side.
// Throughput: s_tready is low in S_RESP, so a new beat is taken only once the last
//   result has been loaded; a stalled output holds the next result back.
// Reset (rst, synchronous): queues empty, push pointer 0, 8 queues in use;
//   the task memory itself is not cleared.
// ----------------------------------------------------------------------------
// work_stealing_multi_queue
// Per-worker FIFO task queues with round-robin push and pop-side stealing.
// ----------------------------------------------------------------------------
`include "work_stealing_multi_queue_defines.svh"

module work_stealing_multi_queue (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [wsmq_pkg::CFG_W-1:0]          cfg_wr_data,  // queues_in_use
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [39:0]                         s_tdata,      // queue_index[2:0], task_handle[34:3]
  input  logic [1:0]                          s_tuser,      // req_type[1:0]
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [39:0]                         m_tdata,      // popped_handle[31:0], source_queue[34:32]
  output logic [2:0]                          m_tuser       // status[1:0], was_stolen[2]
);

  wsmq_pkg::state_t    state;
  wsmq_pkg::state_t    state_next;
  wsmq_pkg::req_t      req;
  wsmq_pkg::decision_t dec;
  wsmq_pkg::decision_t dec_q;

  logic                             fire;
  logic                             out_free;
  logic                             load;
  logic                             mem_we;
  logic                             mem_re;
  logic [wsmq_pkg::AW-1:0]          mem_addr;
  logic [wsmq_pkg::ITEM_WIDTH-1:0]  mem_rdata;
  logic [wsmq_pkg::HANDLE_W-1:0]    out_handle;
  logic [wsmq_pkg::IDX_W-1:0]       out_src;
  wsmq_pkg::status_t                out_status;
  logic                             out_stolen;

  assign req      = wsmq_pkg::req_t'(s_tuser);
  assign fire     = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  wsmq_sched u_sched (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .req         (req),
    .queue_index (s_tdata[2:0]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .dec         (dec),
    .mem_we      (mem_we),
    .mem_re      (mem_re),
    .mem_addr    (mem_addr)
  );

  wsmq_task_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (wsmq_pkg::ITEM_WIDTH'(s_tdata[34:3])),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= wsmq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      wsmq_pkg::S_IDLE: begin
        if (fire && (req != wsmq_pkg::REQ_IGNORE)) begin
          state_next = wsmq_pkg::S_RESP;
        end
      end
      wsmq_pkg::S_RESP: begin
        if (out_free) begin
          state_next = wsmq_pkg::S_IDLE;
        end
      end
      default: state_next = wsmq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    load     = 1'b0;
    case (state)
      wsmq_pkg::S_IDLE: s_tready = 1'b1;
      wsmq_pkg::S_RESP: load     = out_free;
      default: begin
        s_tready = 1'b0;
        load     = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      dec_q <= dec;
    end
  end

  // output register; read data stays valid in the RAM while waiting
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_status <= dec_q.status;
      out_src    <= dec_q.src;
      out_stolen <= dec_q.stolen;
      out_handle <= (dec_q.status == wsmq_pkg::STAT_POPPED) ?
                    wsmq_pkg::HANDLE_W'(mem_rdata) : '0;
    end
  end

  assign m_tdata = {5'b0, out_src, out_handle};
  assign m_tuser = {out_stolen, out_status};

  `WSMQ_ASSERT_NEXT(a_accept_to_resp, fire && (req != wsmq_pkg::REQ_IGNORE), state == wsmq_pkg::S_RESP)
  `WSMQ_ASSERT_IMPL(a_no_accept_in_resp, state == wsmq_pkg::S_RESP, !s_tready)
  `WSMQ_ASSERT_IMPL(a_steal_is_pop, m_tvalid && out_stolen, out_status == wsmq_pkg::STAT_POPPED)
  `WSMQ_ASSERT_NEXT(a_load_shows, load, m_tvalid && (out_status == $past(dec_q.status)))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: work stealing multi queue testbench
// Drives push, pop and ignored requests through the stream ports and checks
// every result beat against its fixed row result or an in-bench model of the
// queues, the round-robin pointer and the steal scan. A directed table goes
// first, then random traffic over several queue counts and idle patterns.
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT_CYCLES = 300000;
  localparam int DRAIN_CYCLES = 4;

  typedef struct packed {
    wsmq_pkg::status_t status;
    logic [31:0]       handle;
    logic [2:0]        src;
    logic              stolen;
  } result_t;

  typedef struct packed {
    bit    on;
    result_t res;
  } fixed_t;

  typedef struct packed {
    bit             is_cfg;
    logic [3:0]     count;
    wsmq_pkg::req_t req;
    logic [2:0]     idx;
    logic [31:0]    handle;
    logic [5:0]     reps;
    bit             fixed;
    result_t        res;
  } step_t;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [3:0]  cfg_wr_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [39:0] s_tdata;   // queue_index[2:0], task_handle[34:3]
  logic [1:0]  s_tuser;   // req_type[1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;   // popped_handle[31:0], source_queue[34:32]
  logic [2:0]  m_tuser;   // status[1:0], was_stolen[2]

  int src_idle;
  int sink_idle;
  int hold_cycles;
  int errors;
  int cycle_count;

  result_t expected_results [$];
  fixed_t  fixed_results [$];
  step_t   plan [$];

  // queue model
  logic [31:0] slots [wsmq_pkg::NUM_QUEUES][wsmq_pkg::QUEUE_DEPTH];
  int unsigned head_ptr [wsmq_pkg::NUM_QUEUES] = '{default: 0};
  int unsigned tail_ptr [wsmq_pkg::NUM_QUEUES] = '{default: 0};
  int unsigned fill [wsmq_pkg::NUM_QUEUES] = '{default: 0};
  int unsigned rr_ptr = 0;
  int unsigned queue_count = 8;

  work_stealing_multi_queue i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int unsigned active_queues();
    if (queue_count == 0) return 1;
    if (queue_count > wsmq_pkg::NUM_QUEUES) return wsmq_pkg::NUM_QUEUES;
    return queue_count;
  endfunction

  function automatic void apply_queue_count(input logic [3:0] v);
    queue_count = v;
    if (rr_ptr >= active_queues()) rr_ptr = 0;
  endfunction

  function automatic logic [31:0] take_head(input int unsigned q);
    logic [31:0] item;
    item = slots[q][head_ptr[q]];
    head_ptr[q] = (head_ptr[q] + 1) % wsmq_pkg::QUEUE_DEPTH;
    fill[q]--;
    return item;
  endfunction

  function automatic bit predict_request(input wsmq_pkg::req_t req, input logic [2:0] idx,
                                         input logic [31:0] handle, output result_t res);
    int unsigned n;
    int unsigned target;
    int unsigned q;
    bit found;
    n = active_queues();
    res = '0;
    found = 1'b0;
    if (req == wsmq_pkg::REQ_IGNORE) return 1'b0;
    if (req != wsmq_pkg::REQ_POP) begin
      if (req == wsmq_pkg::REQ_PUSH_RR) begin
        target = rr_ptr;
        rr_ptr = (rr_ptr + 1 >= n) ? 0 : rr_ptr + 1;
      end else begin
        target = idx;
      end
      res.src = 3'(target);
      if (target < n && fill[target] < wsmq_pkg::QUEUE_DEPTH) begin
        slots[target][tail_ptr[target]] = handle;
        tail_ptr[target] = (tail_ptr[target] + 1) % wsmq_pkg::QUEUE_DEPTH;
        fill[target]++;
        res.status = wsmq_pkg::STAT_PUSHED;
      end else begin
        res.status = wsmq_pkg::STAT_REJECTED;
      end
    end else begin
      if (idx < n && fill[idx] > 0) begin
        res.handle = take_head(idx);
        res.src = idx;
        found = 1'b1;
      end else begin
        for (int k = 1; k <= n && !found; k++) begin
          q = (rr_ptr + n - k) % n;
          if (q != idx && fill[q] > 0) begin
            res.handle = take_head(q);
            res.src = 3'(q);
            res.stolen = 1'b1;
            found = 1'b1;
          end
        end
      end
      res.status = found ? wsmq_pkg::STAT_POPPED : wsmq_pkg::STAT_EMPTY;
    end
    return 1'b1;
  endfunction

  function automatic step_t open_row(input wsmq_pkg::req_t req, input logic [2:0] idx,
                                     input logic [31:0] handle, input logic [5:0] reps);
    step_t s;
    s = '0;
    s.req = req;
    s.idx = idx;
    s.handle = handle;
    s.reps = reps;
    return s;
  endfunction

  function automatic step_t fixed_row(input wsmq_pkg::req_t req, input logic [2:0] idx,
                                      input logic [31:0] handle, input wsmq_pkg::status_t st,
                                      input logic [31:0] ph, input logic [2:0] sq,
                                      input logic ws);
    step_t s;
    s = open_row(req, idx, handle, 6'd1);
    s.fixed = 1'b1;
    s.res.status = st;
    s.res.handle = ph;
    s.res.src = sq;
    s.res.stolen = ws;
    return s;
  endfunction

  function automatic step_t count_row(input logic [3:0] v);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.count = v;
    return s;
  endfunction

  task automatic send_request(input wsmq_pkg::req_t req, input logic [2:0] idx,
                              input logic [31:0] handle, input bit fixed, input result_t want);
    fixed_t f;
    while ($urandom_range(99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    f.on = fixed;
    f.res = want;
    fixed_results.push_back(f);
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {5'b0, handle, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_queue_count(input logic [3:0] v);
    wait_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic send_random(input int push_pct);
    int r;
    wsmq_pkg::req_t req;
    logic [31:0] handle;
    r = $urandom_range(99);
    if (r < push_pct) req = r[0] ? wsmq_pkg::REQ_PUSH_RR : wsmq_pkg::REQ_PUSH_NAMED;
    else if (r < 96) req = wsmq_pkg::REQ_POP;
    else req = wsmq_pkg::REQ_IGNORE;
    case ($urandom_range(15))
      0: handle = '0;
      1: handle = '1;
      default: handle = $urandom;
    endcase
    send_request(req, 3'($urandom_range(7)), handle, 1'b0, '0);
  endtask

  // receiver: random backpressure, or a long hold when asked
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= sink_idle);
      end
    end
  end

  // model update on accepted beats, result check on output beats
  always @(posedge clk) begin : monitor
    result_t want;
    result_t got;
    fixed_t f;
    bit has;
    if (!rst) begin
      if (cfg_wr_en) apply_queue_count(cfg_wr_data);
      if (s_tvalid && s_tready) begin
        f = fixed_results.pop_front();
        has = predict_request(wsmq_pkg::req_t'(s_tuser), s_tdata[2:0], s_tdata[34:3], want);
        if (has) expected_results.push_back(f.on ? f.res : want);
      end
      if (m_tvalid && m_tready) begin
        got.status = wsmq_pkg::status_t'(m_tuser[1:0]);
        got.stolen = m_tuser[2];
        got.handle = m_tdata[31:0];
        got.src = m_tdata[34:32];
        if (expected_results.size() == 0) begin
          $error("result beat with nothing expected: status %0d handle %h", got.status,
                 got.handle);
          errors++;
        end else begin
          want = expected_results.pop_front();
          if (got.status != want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
          end
          if (got.handle != want.handle) begin
            $error("popped_handle: expected %h, got %h", want.handle, got.handle);
            errors++;
          end
          if (got.src != want.src) begin
            $error("source_queue: expected %0d, got %0d", want.src, got.src);
            errors++;
          end
          if (got.stolen != want.stolen) begin
            $error("was_stolen: expected %0d, got %0d", want.stolen, got.stolen);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst = 1'b1;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = '0;
    errors = 0;
    hold_cycles = 0;
    src_idle = 6;
    sink_idle = 70;

    plan.push_back(fixed_row(wsmq_pkg::REQ_POP, 3'd0, 32'h0, wsmq_pkg::STAT_EMPTY,
                             32'h0, 3'd0, 1'b0));
    plan.push_back(fixed_row(wsmq_pkg::REQ_PUSH_RR, 3'd6, 32'hFFFF_FFFF,
                             wsmq_pkg::STAT_PUSHED, 32'h0, 3'd0, 1'b0));
    plan.push_back(fixed_row(wsmq_pkg::REQ_PUSH_NAMED, 3'd7, 32'h0, wsmq_pkg::STAT_PUSHED,
                             32'h0, 3'd7, 1'b0));
    plan.push_back(fixed_row(wsmq_pkg::REQ_PUSH_NAMED, 3'd3, 32'hA5A5_5A5A,
                             wsmq_pkg::STAT_PUSHED, 32'h0, 3'd3, 1'b0));
    plan.push_back(open_row(wsmq_pkg::REQ_IGNORE, 3'd5, 32'h1234_5678, 6'd1));
    plan.push_back(fixed_row(wsmq_pkg::REQ_POP, 3'd0, 32'h0, wsmq_pkg::STAT_POPPED,
                             32'hFFFF_FFFF, 3'd0, 1'b0));
    // own queue empty: steal scan starts below the push pointer
    plan.push_back(fixed_row(wsmq_pkg::REQ_POP, 3'd0, 32'h0, wsmq_pkg::STAT_POPPED,
                             32'h0, 3'd7, 1'b1));
    plan.push_back(fixed_row(wsmq_pkg::REQ_POP, 3'd5, 32'hFFFF_FFFF, wsmq_pkg::STAT_POPPED,
                             32'hA5A5_5A5A, 3'd3, 1'b1));
    plan.push_back(fixed_row(wsmq_pkg::REQ_POP, 3'd2, 32'h0, wsmq_pkg::STAT_EMPTY,
                             32'h0, 3'd0, 1'b0));
    plan.push_back(open_row(wsmq_pkg::REQ_PUSH_NAMED, 3'd4, 32'h0000_1000, 6'd16));
    plan.push_back(fixed_row(wsmq_pkg::REQ_PUSH_NAMED, 3'd4, 32'h0, wsmq_pkg::STAT_REJECTED,
                             32'h0, 3'd4, 1'b0));
    // zero count acts as one, pointer returns to 0
    plan.push_back(count_row(4'd0));
    plan.push_back(fixed_row(wsmq_pkg::REQ_PUSH_NAMED, 3'd2, 32'h0, wsmq_pkg::STAT_REJECTED,
                             32'h0, 3'd2, 1'b0));
    plan.push_back(fixed_row(wsmq_pkg::REQ_PUSH_RR, 3'd0, 32'h1, wsmq_pkg::STAT_PUSHED,
                             32'h0, 3'd0, 1'b0));
    plan.push_back(fixed_row(wsmq_pkg::REQ_POP, 3'd6, 32'h0, wsmq_pkg::STAT_POPPED,
                             32'h1, 3'd0, 1'b1));
    // inactive full queue is out of reach
    plan.push_back(fixed_row(wsmq_pkg::REQ_POP, 3'd4, 32'h0, wsmq_pkg::STAT_EMPTY,
                             32'h0, 3'd0, 1'b0));
    plan.push_back(count_row(4'd15));
    plan.push_back(fixed_row(wsmq_pkg::REQ_POP, 3'd4, 32'h0, wsmq_pkg::STAT_POPPED,
                             32'h0000_1000, 3'd4, 1'b0));
    plan.push_back(open_row(wsmq_pkg::REQ_PUSH_RR, 3'd0, 32'h0000_2000, 6'd16));
    plan.push_back(count_row(4'd5));
    plan.push_back(open_row(wsmq_pkg::REQ_POP, 3'd7, 32'h0, 6'd3));
    plan.push_back(fixed_row(wsmq_pkg::REQ_PUSH_NAMED, 3'd5, 32'h0, wsmq_pkg::STAT_REJECTED,
                             32'h0, 3'd5, 1'b0));
    plan.push_back(open_row(wsmq_pkg::REQ_POP, 3'd0, 32'h0, 6'd24));
    plan.push_back(count_row(4'd8));

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) set_queue_count(plan[i].count);
      else for (int r = 0; r < plan[i].reps; r++)
        send_request(plan[i].req, plan[i].idx, plan[i].handle + r, plan[i].fixed,
                     plan[i].res);
    end

    for (int phase = 0; phase < 3; phase++) begin
      src_idle = (phase == 0) ? 6 : (phase == 1) ? 70 : 0;
      sink_idle = (phase == 0) ? 70 : (phase == 1) ? 6 : 0;
      for (int seg = 0; seg < 6; seg++) begin
        set_queue_count((seg == 0) ? 4'd1 : (seg == 1) ? 4'd8 : 4'($urandom_range(15)));
        if (phase == 2 && seg == 3) hold_cycles = 300;
        begin : segment
          int push_pct;
          push_pct = $urandom_range(30, 70);
          repeat (75) send_random(push_pct);
        end
      end
    end

    wait_results();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
